@@ rtl/core/crp_pkg.sv @@
// Shared types and constants for the cell reference parser.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps

package crp_pkg;

    localparam int COL_W     = 15;
    localparam int ROW_W     = 24;
    localparam int CNT_W     = 4;
    localparam int LCNT_W    = 2;
    localparam int DCNT_W    = 3;
    localparam int VAL_W     = 5;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;

    localparam logic [LCNT_W-1:0] MAX_LETTERS = 2'd3;
    localparam logic [DCNT_W-1:0] MAX_DIGITS  = 3'd7;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_UP_A   = 8'h41;
    localparam logic [7:0] CHAR_UP_Z   = 8'h5A;
    localparam logic [7:0] CHAR_LO_A   = 8'h61;
    localparam logic [7:0] CHAR_LO_Z   = 8'h7A;

    // register index, taken from paddr[2]
    localparam logic REG_COL_LIMIT = 1'b0;
    localparam logic REG_ROW_LIMIT = 1'b1;

    localparam logic [COL_W-1:0] COL_LIMIT_RST = 15'd16384;
    localparam logic [ROW_W-1:0] ROW_LIMIT_RST = 24'd1048576;

    typedef enum logic [1:0] {
        CLS_OTHER,
        CLS_LETTER,
        CLS_DIGIT,
        CLS_DOLLAR
    } t_cls;

    // classified character handed from front to back
    typedef struct packed {
        logic             start;
        t_cls             cls;
        logic [VAL_W-1:0] val;    // letter 1..26 or digit 0..9
    } t_tok;

    // decided reference handed from back to result stage
    typedef struct packed {
        logic             fail;
        logic [ROW_W-1:0] row_acc;
        logic [COL_W-1:0] col_acc;
        logic             row_abs;
        logic             col_abs;
        logic [CNT_W-1:0] count;
    } t_dec;

    typedef struct packed {
        logic [COL_W-1:0] col_limit;
        logic [ROW_W-1:0] row_limit;
    } t_limits;

endpackage

@@ rtl/core/crp_ifs.sv @@
// Valid/ready channel interfaces for the parser's input and result streams.
// Depends on crp_pkg for field widths.
`timescale 1ns / 1ps

interface crp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       start_req;

    modport source (output valid, output char_in, output start_req, input ready);
    modport sink   (input valid, input char_in, input start_req, output ready);
endinterface

interface crp_out_if
    import crp_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             ok;
    logic [ROW_W-1:0] row_index;
    logic [COL_W-1:0] col_index;
    logic             row_absolute;
    logic             col_absolute;
    logic [CNT_W-1:0] consumed;

    modport source (output valid, output ok, output row_index, output col_index,
                    output row_absolute, output col_absolute, output consumed,
                    input ready);
    modport sink   (input valid, input ok, input row_index, input col_index,
                    input row_absolute, input col_absolute, input consumed,
                    output ready);
endinterface

@@ rtl/core/cell_reference_parser_unit.sv @@
// Path of a result: token queue, back decision register, output register.
// Throughput: one character per cycle; the back-end state machine takes one token a cycle.
// The input stalls only when the two-entry token queue fills behind a stalled output.
// Reset (i_rst_n low, synchronous): queue empty, parser idle, no result pending,
// column_limit = 16384, row_limit = 1048576.
`timescale 1ns / 1ps

module cell_reference_parser_unit
    import crp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // character stream in, one transaction per character
    crp_in_if.sink            i_in,
    // decided references out
    crp_out_if.source         o_res,
    // APB-style configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    // ------------------------------------------------------------------
    // Configuration registers. Writes land in the access phase; the
    // register index is paddr[2] (registers at byte 0 and byte 4).
    // ------------------------------------------------------------------
    logic [COL_W-1:0] r_col_limit;
    logic [ROW_W-1:0] r_row_limit;
    logic             w_cfg_wr;
    t_limits          w_limits;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_limit <= COL_LIMIT_RST;
            r_row_limit <= ROW_LIMIT_RST;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_COL_LIMIT) begin
                r_col_limit <= pwdata[COL_W-1:0];
            end
            if (paddr[2] == REG_ROW_LIMIT) begin
                r_row_limit <= pwdata[ROW_W-1:0];
            end
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_COL_LIMIT: prdata = {{(APB_DW-COL_W){1'b0}}, r_col_limit};
            REG_ROW_LIMIT: prdata = {{(APB_DW-ROW_W){1'b0}}, r_row_limit};
            default:       prdata = '0;
        endcase
    end

    assign w_limits.col_limit = r_col_limit;
    assign w_limits.row_limit = r_row_limit;

    // ------------------------------------------------------------------
    // Front: classify each character into a token (letter value, digit
    // value, dollar, other) and push it into the queue.
    // ------------------------------------------------------------------
    logic w_push;
    t_tok w_front_tok;
    logic w_q_full;

    crp_front u_front (
        .i_in     (i_in),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_tok    (w_front_tok)
    );

    // Short queue decouples the front from back-end stalls.
    logic w_q_valid;
    t_tok w_q_tok;
    logic w_pop;

    crp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_tok   (w_front_tok),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_tok   (w_q_tok)
    );

    // ------------------------------------------------------------------
    // Back: grammar walk and accumulation. A decided reference sits in
    // the back's decision register until the result stage takes it.
    // ------------------------------------------------------------------
    logic w_adv;
    logic w_dec_valid;
    t_dec w_dec;

    crp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (w_q_valid),
        .i_tok       (w_q_tok),
        .o_pop       (w_pop),
        .i_adv       (w_adv),
        .o_dec_valid (w_dec_valid),
        .o_dec       (w_dec)
    );

    // Result stage: bound checks, zeroing on failure, output register.
    crp_result u_result (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dec_valid (w_dec_valid),
        .i_dec       (w_dec),
        .i_limits    (w_limits),
        .o_adv       (w_adv),
        .o_res       (o_res)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // a failed result carries all-zero fields
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ok) |-> (o_res.row_index == '0 && o_res.col_index == '0 &&
                                        o_res.consumed == '0 && !o_res.row_absolute &&
                                        !o_res.col_absolute))
        else $error("failed result with nonzero fields");

    // a good reference has at least one letter and one digit, at most 12 chars
    a_ok_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.ok) |-> (o_res.consumed >= 4'd2 && o_res.consumed <= 4'd12))
        else $error("successful result with impossible character count");

    // a good reference lies inside the configured bounds
    a_ok_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.ok) |-> (o_res.row_index < r_row_limit &&
                                       o_res.col_index < r_col_limit))
        else $error("successful result out of bounds");

    // nothing is popped from an empty queue
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("token popped from empty queue");

endmodule

@@ rtl/core/crp_front.sv @@
// Front end: accepts characters and classifies them into tokens.
// Depends on crp_pkg and crp_in_if.
`timescale 1ns / 1ps

module crp_front
    import crp_pkg::*;
(
    crp_in_if.sink  i_in,
    input  logic    i_q_full,
    output logic    o_push,
    output t_tok    o_tok
);

    logic [7:0] w_ch;
    logic       w_letter;
    logic       w_digit;

    assign w_ch     = i_in.char_in;
    assign w_letter = ((w_ch >= CHAR_UP_A) && (w_ch <= CHAR_UP_Z)) ||
                      ((w_ch >= CHAR_LO_A) && (w_ch <= CHAR_LO_Z));
    assign w_digit  = (w_ch >= CHAR_ZERO) && (w_ch <= CHAR_NINE);

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

    always_comb begin
        o_tok.start = i_in.start_req;
        o_tok.val   = '0;
        if (w_letter) begin
            o_tok.cls = CLS_LETTER;
            // low five bits of 'A'..'Z' and 'a'..'z' are already 1..26
            o_tok.val = w_ch[VAL_W-1:0];
        end else if (w_digit) begin
            o_tok.cls = CLS_DIGIT;
            o_tok.val = {1'b0, w_ch[3:0]};
        end else if (w_ch == CHAR_DOLLAR) begin
            o_tok.cls = CLS_DOLLAR;
        end else begin
            o_tok.cls = CLS_OTHER;
        end
    end

endmodule

@@ rtl/core/crp_queue.sv @@
// Two-entry token queue between front and back.
// Depends on crp_pkg.
`timescale 1ns / 1ps

module crp_queue
    import crp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_tok i_tok,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_tok o_tok
);

    t_tok       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_tok   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop  ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

@@ rtl/core/crp_back.sv @@
// Back end: grammar state machine and accumulators; takes one token per cycle
// unless stalled. Depends on crp_pkg; hands decided references to crp_result.
`timescale 1ns / 1ps

module crp_back
    import crp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_tok_valid,
    input  t_tok i_tok,
    output logic o_pop,
    input  logic i_adv,
    output logic o_dec_valid,
    output t_dec o_dec
);

    localparam logic [2:0] PH_IDLE         = 3'd0;
    localparam logic [2:0] PH_BEGIN        = 3'd1;
    localparam logic [2:0] PH_LETTER_FIRST = 3'd2;
    localparam logic [2:0] PH_LETTERS      = 3'd3;
    localparam logic [2:0] PH_DIGIT_FIRST  = 3'd4;
    localparam logic [2:0] PH_DIGITS       = 3'd5;

    logic [2:0]        r_phase,   n_phase;
    logic [COL_W-1:0]  r_col,     n_col;
    logic [ROW_W-1:0]  r_row,     n_row;
    logic [LCNT_W-1:0] r_lcnt,    n_lcnt;
    logic [DCNT_W-1:0] r_dcnt,    n_dcnt;
    logic              r_col_abs, n_col_abs;
    logic              r_row_abs, n_row_abs;
    logic [CNT_W-1:0]  r_cnt,     n_cnt;
    logic              r_dec_valid, n_dec_valid;
    t_dec              r_dec,     n_dec;

    logic [2:0]        w_phase;
    logic [COL_W-1:0]  w_col;
    logic [ROW_W-1:0]  w_row;
    logic [LCNT_W-1:0] w_lcnt;
    logic [DCNT_W-1:0] w_dcnt;
    logic              w_col_abs;
    logic              w_row_abs;
    logic [CNT_W-1:0]  w_cnt;
    logic [COL_W+4:0]  w_col_mul;
    logic [ROW_W+3:0]  w_row_mul;
    logic [COL_W-1:0]  w_col_next;
    logic [ROW_W-1:0]  w_row_next;
    logic [DCNT_W-1:0] w_dcnt_next;
    logic [CNT_W-1:0]  w_cnt_next;
    logic              w_dec_ready;
    logic              w_emit;

    assign w_dec_ready = !r_dec_valid || i_adv;
    assign o_pop       = i_tok_valid && w_dec_ready;
    assign o_dec_valid = r_dec_valid;
    assign o_dec       = r_dec;

    // a start token discards any reference in progress
    always_comb begin
        w_phase   = i_tok.start ? PH_BEGIN : r_phase;
        w_col     = i_tok.start ? '0 : r_col;
        w_row     = i_tok.start ? '0 : r_row;
        w_lcnt    = i_tok.start ? '0 : r_lcnt;
        w_dcnt    = i_tok.start ? '0 : r_dcnt;
        w_col_abs = i_tok.start ? 1'b0 : r_col_abs;
        w_row_abs = i_tok.start ? 1'b0 : r_row_abs;
        w_cnt     = i_tok.start ? '0 : r_cnt;
    end

    // col*26 + letter, row*10 + digit, as shift-adds
    always_comb begin
        w_col_mul   = {1'b0, w_col, 4'b0} + {2'b0, w_col, 3'b0} + {4'b0, w_col, 1'b0}
                    + {{(COL_W){1'b0}}, i_tok.val};
        w_row_mul   = {1'b0, w_row, 3'b0} + {3'b0, w_row, 1'b0}
                    + {{(ROW_W-1){1'b0}}, i_tok.val};
        w_col_next  = w_col_mul[COL_W-1:0];
        w_row_next  = w_row_mul[ROW_W-1:0];
        w_dcnt_next = w_dcnt + 1'b1;
        w_cnt_next  = w_cnt + 1'b1;
    end

    always_comb begin
        n_phase     = r_phase;
        n_col       = r_col;
        n_row       = r_row;
        n_lcnt      = r_lcnt;
        n_dcnt      = r_dcnt;
        n_col_abs   = r_col_abs;
        n_row_abs   = r_row_abs;
        n_cnt       = r_cnt;
        w_emit      = 1'b0;
        n_dec.fail    = 1'b1;
        n_dec.row_acc = w_row;
        n_dec.col_acc = w_col;
        n_dec.row_abs = w_row_abs;
        n_dec.col_abs = w_col_abs;
        n_dec.count   = w_cnt;

        if (o_pop) begin
            n_phase   = w_phase;
            n_col     = w_col;
            n_row     = w_row;
            n_lcnt    = w_lcnt;
            n_dcnt    = w_dcnt;
            n_col_abs = w_col_abs;
            n_row_abs = w_row_abs;
            n_cnt     = w_cnt;

            unique case (w_phase)
                PH_BEGIN, PH_LETTER_FIRST: begin
                    if (i_tok.cls == CLS_LETTER) begin
                        n_col   = w_col_next;
                        n_lcnt  = w_lcnt + 1'b1;
                        n_cnt   = w_cnt_next;
                        n_phase = PH_LETTERS;
                    end else if (i_tok.cls == CLS_DOLLAR && w_phase == PH_BEGIN) begin
                        n_col_abs = 1'b1;
                        n_cnt     = w_cnt_next;
                        n_phase   = PH_LETTER_FIRST;
                    end else begin
                        w_emit  = 1'b1;
                        n_phase = PH_IDLE;
                    end
                end
                PH_LETTERS, PH_DIGIT_FIRST, PH_DIGITS: begin
                    priority if (i_tok.cls == CLS_LETTER && w_phase == PH_LETTERS &&
                                 w_lcnt < MAX_LETTERS) begin
                        n_col  = w_col_next;
                        n_lcnt = w_lcnt + 1'b1;
                        n_cnt  = w_cnt_next;
                    end else if (i_tok.cls == CLS_DOLLAR && w_phase == PH_LETTERS) begin
                        n_row_abs = 1'b1;
                        n_cnt     = w_cnt_next;
                        n_phase   = PH_DIGIT_FIRST;
                    end else if (i_tok.cls == CLS_DIGIT) begin
                        n_row   = w_row_next;
                        n_dcnt  = w_dcnt_next;
                        n_cnt   = w_cnt_next;
                        n_phase = PH_DIGITS;
                        // seventh digit closes the reference and belongs to it
                        if (w_dcnt_next >= MAX_DIGITS) begin
                            w_emit        = 1'b1;
                            n_phase       = PH_IDLE;
                            n_dec.fail    = 1'b0;
                            n_dec.row_acc = w_row_next;
                            n_dec.count   = w_cnt_next;
                        end
                    end else if (w_phase == PH_DIGITS) begin
                        // terminator: decide on what has been gathered
                        w_emit     = 1'b1;
                        n_phase    = PH_IDLE;
                        n_dec.fail = (w_dcnt == '0);
                    end else begin
                        w_emit  = 1'b1;
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end

        n_dec_valid = (r_dec_valid && !i_adv) || w_emit;
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_dec <= n_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_lcnt      <= '0;
            r_dcnt      <= '0;
            r_col_abs   <= 1'b0;
            r_row_abs   <= 1'b0;
            r_cnt       <= '0;
            r_dec_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_col       <= n_col;
            r_row       <= n_row;
            r_lcnt      <= n_lcnt;
            r_dcnt      <= n_dcnt;
            r_col_abs   <= n_col_abs;
            r_row_abs   <= n_row_abs;
            r_cnt       <= n_cnt;
            r_dec_valid <= n_dec_valid;
        end
    end

endmodule

@@ rtl/core/crp_result.sv @@
// Result stage: bound checks on a decided reference and the output register.
// Depends on crp_pkg and crp_out_if.
`timescale 1ns / 1ps

module crp_result
    import crp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_dec_valid,
    input  t_dec       i_dec,
    input  t_limits    i_limits,
    output logic       o_adv,
    crp_out_if.source  o_res
);

    logic             r_valid, n_valid;
    logic             r_ok;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic             r_row_abs;
    logic             r_col_abs;
    logic [CNT_W-1:0] r_cnt;
    logic             w_ok;

    // acc - 1 < limit  <=>  acc <= limit, once acc is nonzero
    assign w_ok = !i_dec.fail && (i_dec.row_acc != '0) && (i_dec.col_acc != '0) &&
                  (i_dec.row_acc <= i_limits.row_limit) &&
                  (i_dec.col_acc <= i_limits.col_limit);

    assign o_adv   = !r_valid || o_res.ready;
    assign n_valid = o_adv ? i_dec_valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (o_adv && i_dec_valid) begin
            r_ok      <= w_ok;
            r_row     <= w_ok ? i_dec.row_acc - 1'b1 : '0;
            r_col     <= w_ok ? i_dec.col_acc - 1'b1 : '0;
            r_row_abs <= w_ok && i_dec.row_abs;
            r_col_abs <= w_ok && i_dec.col_abs;
            r_cnt     <= w_ok ? i_dec.count : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.ok           = r_ok;
    assign o_res.row_index    = r_row;
    assign o_res.col_index    = r_col;
    assign o_res.row_absolute = r_row_abs;
    assign o_res.col_absolute = r_col_abs;
    assign o_res.consumed     = r_cnt;

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for cell_reference_parser_unit: characters in, references out.
// Depends on crp_pkg and the channel interfaces in crp_ifs.sv.
// Stimulus is a short directed list followed by randomized references over several limit settings.
`timescale 1ns / 1ps

module testbench;
    import crp_pkg::*;

    // Cycles to wait after the last expected result before touching the limits or ending.
    // This covers anything still in flight through the block's registers.
    localparam int DRAIN_CYCLES = 6;
    // Length of the long output hold-off, in clock cycles
    localparam int HOLD_CYCLES  = 80;
    // Random transactions per limit setting
    localparam int PHASE_ITEMS  = 150;
    localparam int N_PHASES     = 8;
    // A limit of -1 in the setting lists means "pick at random"
    localparam int COL_SETTING [N_PHASES] = '{16384, 18278, 32767, 1, 0, -1, 702, -1};
    localparam int ROW_SETTING [N_PHASES] = '{1048576, 9999999, 16777215, 1, 0, -1, 100, -1};

    // Parser phases of the predictor, one per position in the reference grammar
    typedef enum logic [2:0] {
        PS_IDLE,
        PS_BEGIN,
        PS_COL_FIRST,
        PS_COLS,
        PS_ROW_FIRST,
        PS_ROWS
    } t_parse_ph;

    // One decided reference as it appears on the result channel
    typedef struct packed {
        logic             ok;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             row_abs;
        logic             col_abs;
        logic [CNT_W-1:0] used;
    } t_ref_res;

    // One character transaction; typed rows carry their expected reference
    typedef struct packed {
        logic [7:0] ch;
        logic       st;
        logic       typed;
        t_ref_res   exp;
    } t_row;

    localparam t_ref_res NO_REF   = '0;
    localparam t_ref_res FAIL_REF = '0;

    // Directed part: dollars and lower case, the largest in-bounds reference at reset limits
    // (decided on its seventh digit), a start that abandons a reference, a zero row,
    // a dollar with no letters, an ignored character between references, and a NUL start.
    localparam int N_DIR = 23;
    localparam t_row DIR_ROWS [N_DIR] = '{
        {"$",   1'b1, 1'b0, NO_REF},
        {"a",   1'b0, 1'b0, NO_REF},
        {"$",   1'b0, 1'b0, NO_REF},
        {"1",   1'b0, 1'b0, NO_REF},
        {" ",   1'b0, 1'b1, {1'b1, 24'd0, 15'd0, 1'b1, 1'b1, 4'd4}},
        {"X",   1'b1, 1'b0, NO_REF},
        {"F",   1'b0, 1'b0, NO_REF},
        {"D",   1'b0, 1'b0, NO_REF},
        {"1",   1'b0, 1'b0, NO_REF},
        {"0",   1'b0, 1'b0, NO_REF},
        {"4",   1'b0, 1'b0, NO_REF},
        {"8",   1'b0, 1'b0, NO_REF},
        {"5",   1'b0, 1'b0, NO_REF},
        {"7",   1'b0, 1'b0, NO_REF},
        {"6",   1'b0, 1'b1, {1'b1, 24'd1048575, 15'd16383, 1'b0, 1'b0, 4'd10}},
        {"B",   1'b1, 1'b0, NO_REF},
        {"c",   1'b1, 1'b0, NO_REF},
        {"0",   1'b0, 1'b0, NO_REF},
        {8'hFF, 1'b0, 1'b1, FAIL_REF},
        {"$",   1'b1, 1'b0, NO_REF},
        {"9",   1'b0, 1'b1, FAIL_REF},
        {8'h00, 1'b0, 1'b0, NO_REF},
        {8'h00, 1'b1, 1'b1, FAIL_REF}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    crp_in_if  in_ch ();
    crp_out_if res_ch ();

    cell_reference_parser_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the parser and its limits
    // ------------------------------------------------------------------
    t_parse_ph        ps;
    logic [COL_W-1:0] col_acc;
    logic [ROW_W-1:0] row_acc;
    int               n_letters;
    int               n_digits;
    logic             col_dol;
    logic             row_dol;
    logic [CNT_W-1:0] n_chars;
    logic [COL_W-1:0] lim_col;
    logic [ROW_W-1:0] lim_row;

    t_ref_res decided_refs [$];   // references predicted but not yet seen on o_res
    int       errors     = 0;
    int       items_done = 0;     // accepted characters that were not ignored
    bit       steady     = 1'b0;  // no idling on either side while set
    bit       hold_req   = 1'b0;  // asks the receiver for one long hold-off

    function automatic t_cls char_class(input logic [7:0] ch);
        if (ch == CHAR_DOLLAR)
            return CLS_DOLLAR;
        if (ch >= CHAR_ZERO && ch <= CHAR_NINE)
            return CLS_DIGIT;
        if ((ch >= CHAR_UP_A && ch <= CHAR_UP_Z) || (ch >= CHAR_LO_A && ch <= CHAR_LO_Z))
            return CLS_LETTER;
        return CLS_OTHER;
    endfunction

    function automatic void clear_parse_state();
        col_acc   = '0;
        row_acc   = '0;
        n_letters = 0;
        n_digits  = 0;
        col_dol   = 1'b0;
        row_dol   = 1'b0;
        n_chars   = '0;
    endfunction

    // Ends the reference in progress. A forced failure, missing parts, a zero row or
    // an out-of-bounds index all give the all-zero result.
    function automatic bit close_reference(input bit fail, output t_ref_res res);
        logic [31:0] c;
        logic [31:0] r;
        c   = 32'(col_acc) - 32'd1;
        r   = 32'(row_acc) - 32'd1;
        res = '0;
        ps  = PS_IDLE;
        if (!fail && n_digits != 0 && row_acc != 0 && col_acc != 0
                && c < 32'(lim_col) && r < 32'(lim_row)) begin
            res.ok      = 1'b1;
            res.row     = r[ROW_W-1:0];
            res.col     = c[COL_W-1:0];
            res.row_abs = row_dol;
            res.col_abs = col_dol;
            res.used    = n_chars;
        end
        return 1'b1;
    endfunction

    // Bijective base 26, case-insensitive: A=1 .. Z=26, AA=27
    function automatic void add_letter(input logic [7:0] ch);
        logic [7:0]  up;
        logic [31:0] acc;
        up      = (ch >= CHAR_LO_A) ? ch - 8'd32 : ch;
        acc     = 32'(col_acc) * 32'd26 + 32'(up - CHAR_UP_A) + 32'd1;
        col_acc = acc[COL_W-1:0];
        n_letters++;
        n_chars++;
    endfunction

    // The digit that fills the row field decides the reference on the spot
    function automatic bit add_digit(input logic [7:0] ch, output t_ref_res res);
        logic [31:0] acc;
        acc     = 32'(row_acc) * 32'd10 + 32'(ch - CHAR_ZERO);
        row_acc = acc[ROW_W-1:0];
        n_digits++;
        n_chars++;
        ps  = PS_ROWS;
        res = '0;
        if (n_digits >= int'(MAX_DIGITS))
            return close_reference(1'b0, res);
        return 1'b0;
    endfunction

    // Advances the predicted parser by one character; returns 1 when a reference is decided
    function automatic bit parse_char(input logic [7:0] ch, input logic st,
                                      output t_ref_res res);
        t_cls cl;
        cl  = char_class(ch);
        res = '0;
        // a start abandons whatever was in progress, without a result
        if (st) begin
            clear_parse_state();
            ps = PS_BEGIN;
        end
        case (ps)
            PS_BEGIN: begin
                if (cl == CLS_DOLLAR) begin
                    col_dol = 1'b1;
                    n_chars++;
                    ps = PS_COL_FIRST;
                    return 1'b0;
                end
                if (cl == CLS_LETTER) begin
                    add_letter(ch);
                    ps = PS_COLS;
                    return 1'b0;
                end
            end
            PS_COL_FIRST: begin
                if (cl == CLS_LETTER) begin
                    add_letter(ch);
                    ps = PS_COLS;
                    return 1'b0;
                end
            end
            PS_COLS: begin
                if (cl == CLS_LETTER && n_letters < int'(MAX_LETTERS)) begin
                    add_letter(ch);
                    return 1'b0;
                end
                if (cl == CLS_DOLLAR) begin
                    row_dol = 1'b1;
                    n_chars++;
                    ps = PS_ROW_FIRST;
                    return 1'b0;
                end
                if (cl == CLS_DIGIT)
                    return add_digit(ch, res);
            end
            PS_ROW_FIRST: begin
                if (cl == CLS_DIGIT)
                    return add_digit(ch, res);
            end
            PS_ROWS: begin
                // any non-digit ends a well-formed row; it is not part of the reference
                if (cl == CLS_DIGIT)
                    return add_digit(ch, res);
                return close_reference(1'b0, res);
            end
            default: begin
                // no reference in progress: the character is dropped
                return 1'b0;
            end
        endcase
        return close_reference(1'b1, res);
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    function automatic int clip_to(input int v, input int lo, input int hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    // ------------------------------------------------------------------
    // Character sender: random gaps, then hold the transaction until accepted.
    // The prediction is made at the accepting edge.
    // ------------------------------------------------------------------
    task automatic send_char(input t_row row);
        t_ref_res res;
        bit       decided;
        bit       ignored;
        if (!steady) begin
            while ($urandom_range(99) < 33) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        in_ch.valid     <= 1'b1;
        in_ch.char_in   <= row.ch;
        in_ch.start_req <= row.st;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        ignored = (ps == PS_IDLE) && !row.st;
        decided = parse_char(row.ch, row.st, res);
        if (decided)
            decided_refs.push_back(row.typed ? row.exp : res);
        if (!ignored)
            items_done++;
    endtask

    // Builds one random reference (well-formed most of the time, sometimes corrupted,
    // sometimes plain noise) and sends it. Values are steered toward the current limits.
    task automatic send_reference();
        t_row       seq [$];
        t_row       r;
        int         kind;
        int         cval;
        int         rval;
        int         ndig;
        int         nd_min;
        int         v;
        int         k;
        logic [7:0] b;
        t_row       letters [$];
        kind = $urandom_range(99);
        r    = '0;
        if (kind >= 88) begin
            // noise: random bytes with scattered starts
            repeat ($urandom_range(6, 1)) begin
                r.ch = 8'($urandom);
                r.st = ($urandom_range(3) == 0);
                seq.push_back(r);
            end
        end else begin
            case ($urandom_range(3))
                0:       cval = $urandom_range(26, 1);
                1:       cval = $urandom_range(702, 1);
                2:       cval = $urandom_range(18278, 1);
                default: cval = clip_to(int'(lim_col) + $urandom_range(2), 1, 18278);
            endcase
            case ($urandom_range(2))
                0:       rval = -1;
                1:       rval = clip_to(int'(lim_row) + $urandom_range(2), 0, 9999999);
                default: rval = $urandom_range(999);
            endcase
            if ($urandom_range(1)) begin
                r.ch = CHAR_DOLLAR;
                seq.push_back(r);
            end
            // column letters, most significant first, random case
            v = cval;
            while (v > 0) begin
                v--;
                r.ch = CHAR_UP_A + 8'(v % 26);
                if ($urandom_range(1))
                    r.ch = r.ch | 8'h20;
                letters.push_front(r);
                v = v / 26;
            end
            foreach (letters[k])
                seq.push_back(letters[k]);
            // broken sequences sometimes carry one extra letter
            if (kind >= 70 && $urandom_range(2) == 0) begin
                r.ch = CHAR_UP_A + 8'($urandom_range(25));
                seq.push_back(r);
            end
            if ($urandom_range(1)) begin
                r.ch = CHAR_DOLLAR;
                seq.push_back(r);
            end
            if (rval < 0) begin
                ndig = $urandom_range(7, 1);
                repeat (ndig) begin
                    r.ch = CHAR_ZERO + 8'($urandom_range(9));
                    seq.push_back(r);
                end
            end else begin
                nd_min = 1;
                v = rval;
                while (v >= 10) begin
                    v = v / 10;
                    nd_min++;
                end
                // leading zeros now and then
                ndig = ($urandom_range(3) == 0) ? $urandom_range(7, nd_min) : nd_min;
                letters.delete();
                v = rval;
                for (k = 0; k < ndig; k++) begin
                    r.ch = CHAR_ZERO + 8'(v % 10);
                    letters.push_front(r);
                    v = v / 10;
                end
                foreach (letters[k])
                    seq.push_back(letters[k]);
            end
            // a short row needs a terminator; without one the next start abandons it
            if (ndig < 7 ? $urandom_range(9) < 8 : $urandom_range(3) == 0) begin
                do b = 8'($urandom); while (char_class(b) == CLS_DIGIT);
                r.ch = b;
                seq.push_back(r);
            end
            if (kind >= 70 && seq.size() > 1)
                seq[$urandom_range(seq.size() - 1, 1)].ch = 8'($urandom);
            seq[0].st = 1'b1;
        end
        foreach (seq[k])
            send_char(seq[k]);
    endtask

    // Waits until every predicted reference has been seen, then lets the pipe drain
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (decided_refs.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // APB write followed by a read back of the same register
    task automatic limit_write(input logic idx, input logic [31:0] val);
        logic [31:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_COL_LIMIT)
            lim_col = val[COL_W-1:0];
        else
            lim_row = val[ROW_W-1:0];
        want = (idx == REG_COL_LIMIT) ? 32'(lim_col) : 32'(lim_row);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== want)
            report_mismatch($sformatf("limit %0d read back %0h, want %0h", idx, prdata, want));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result receiver: random back-pressure, steady stretches, one long hold-off
    // ------------------------------------------------------------------
    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else begin
                res_ch.ready <= steady || ($urandom_range(99) >= 33);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every accepted result against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_ref_res want;
        if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            if (decided_refs.size() == 0) begin
                report_mismatch("result transaction with no reference predicted");
            end else begin
                want = decided_refs.pop_front();
                if (res_ch.ok !== want.ok)
                    report_mismatch($sformatf("ok %0b, want %0b", res_ch.ok, want.ok));
                if (res_ch.row_index !== want.row)
                    report_mismatch($sformatf("row_index %0d, want %0d",
                                              res_ch.row_index, want.row));
                if (res_ch.col_index !== want.col)
                    report_mismatch($sformatf("col_index %0d, want %0d",
                                              res_ch.col_index, want.col));
                if (res_ch.row_absolute !== want.row_abs)
                    report_mismatch($sformatf("row_absolute %0b, want %0b",
                                              res_ch.row_absolute, want.row_abs));
                if (res_ch.col_absolute !== want.col_abs)
                    report_mismatch($sformatf("col_absolute %0b, want %0b",
                                              res_ch.col_absolute, want.col_abs));
                if (res_ch.consumed !== want.used)
                    report_mismatch($sformatf("consumed %0d, want %0d",
                                              res_ch.consumed, want.used));
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int ph;
        int i;
        int cfg_col;
        int cfg_row;
        bit paused;

        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.char_in   <= '0;
        in_ch.start_req <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        ps      = PS_IDLE;
        lim_col = COL_LIMIT_RST;
        lim_row = ROW_LIMIT_RST;
        clear_parse_state();
        paused  = 1'b0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed list, at reset limits
        for (i = 0; i < N_DIR; i++)
            send_char(DIR_ROWS[i]);
        items_done = 0;

        for (ph = 0; ph < N_PHASES; ph++) begin
            drain_results();
            cfg_col = (COL_SETTING[ph] < 0) ? $urandom_range(18278, 1) : COL_SETTING[ph];
            cfg_row = (ROW_SETTING[ph] < 0) ? $urandom_range(9999999, 1) : ROW_SETTING[ph];
            limit_write(REG_COL_LIMIT, 32'(cfg_col));
            limit_write(REG_ROW_LIMIT, 32'(cfg_row));
            // one phase with no idling anywhere
            steady = (ph == 2);
            // stall the output for a long while as the sender keeps going; the token
            // queue fills and the input must stall
            if (ph == 1)
                hold_req = 1'b1;
            while (items_done < (ph + 1) * PHASE_ITEMS) begin
                send_reference();
                // one pause of the sender until everything predicted has come out
                if (ph == 5 && !paused && items_done >= ph * PHASE_ITEMS + PHASE_ITEMS / 2) begin
                    paused = 1'b1;
                    in_ch.valid <= 1'b0;
                    do @(posedge i_clk); while (decided_refs.size() != 0);
                end
            end
        end

        drain_results();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Guard against a hung handshake: far beyond the slowest correct run
    initial begin
        #(2_000_000);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/crp_pkg.sv
rtl/core/crp_ifs.sv
rtl/core/crp_front.sv
rtl/core/crp_queue.sv
rtl/core/crp_back.sv
rtl/core/crp_result.sv
rtl/core/cell_reference_parser_unit.sv
verif/testbench.sv
